FILE: hw/rtl/swc_pkg.sv
package swc_pkg;

  localparam int SampleW = 16;
  localparam int WinW    = 11;
  localparam int WinMax  = 1024;
  localparam int AddrW   = $clog2(WinMax);
  localparam logic [WinW-1:0] WinReset = 11'd10;
  localparam int WinMin  = 2;

  localparam int SumW    = 27;
  localparam int SqW     = 41;
  localparam int XyW     = 42;
  localparam int ProdW   = 2 * SampleW;
  localparam int MulOpW  = XyW + 1;
  localparam int PnW     = WinW + 1 + MulOpW;
  localparam int PsW     = 2 * SumW;

  localparam int VarW    = 51;
  localparam int CovW    = 52;
  localparam int RadW    = 2 * VarW;
  localparam int RootW   = VarW;
  localparam int HalfW   = 26;
  localparam int DivW    = 20;
  localparam int FracW   = 17;
  localparam int CorrW   = 18;
  localparam int CovOutW = 32;
  localparam int CntW    = 6;

  localparam int QDepth  = 2;
  localparam int QPtrW   = $clog2(QDepth);

  typedef struct packed {
    logic                   full;
    logic [VarW-1:0]        a;
    logic [VarW-1:0]        b;
    logic signed [CovW-1:0] c;
    logic [WinW-1:0]        n;
  } swc_job_t;

  typedef enum logic [2:0] {
    F_IDLE,
    F_LOAD,
    F_SUM,
    F_MUL,
    F_PUSH
  } front_state_e;

  typedef enum logic [2:0] {
    B_IDLE,
    B_MUL,
    B_SQRT,
    B_DINIT,
    B_DIV,
    B_OUT
  } back_state_e;

endpackage

FILE: hw/rtl/swc_if.sv
interface swc_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [swc_pkg::SampleW-1:0] x_sample;
  logic signed [swc_pkg::SampleW-1:0] y_sample;
  logic                                restart;
  modport source (output valid, x_sample, y_sample, restart, input ready);
  modport sink (input valid, x_sample, y_sample, restart, output ready);
endinterface

interface swc_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [swc_pkg::WinW-1:0]     window_length;
  modport source (output valid, window_length, input ready);
  modport sink (input valid, window_length, output ready);
endinterface

interface swc_out_if;
  logic                                valid;
  logic                                ready;
  logic                                result_valid;
  logic signed [swc_pkg::CorrW-1:0]   correlation;
  logic signed [swc_pkg::CovOutW-1:0] covariance;
  logic                                correlation_undefined;
  modport source (output valid, result_valid, correlation, covariance,
                  correlation_undefined, input ready);
  modport sink (input valid, result_valid, correlation, covariance,
                correlation_undefined, output ready);
endinterface

FILE: hw/rtl/swc_ram.sv
module swc_ram #(
  parameter int Width = 32,
  parameter int Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

FILE: hw/rtl/swc_front.sv
module swc_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  swc_in_if.sink            sample_i,
  swc_cfg_if.sink           cfg_i,
  output logic              job_valid_o,
  input  logic              job_ready_i,
  output swc_pkg::swc_job_t job_o
);
  import swc_pkg::*;

  front_state_e state_q, state_d;

  logic [WinW-1:0]  window_length_q;
  logic [WinW-1:0]  n_eff;
  logic [WinW-1:0]  fill_q, fill_eff, fill_new;
  logic [AddrW-1:0] widx_q, widx_eff, raddr;
  logic             drop_d, drop_q, full_q;
  logic             accept, cfg_we;
  logic [1:0]       k_q;

  logic signed [SumW-1:0] sx_q, sy_q;
  logic [SqW-1:0]         sxx_q, syy_q;
  logic signed [XyW-1:0]  sxy_q;

  logic signed [SampleW-1:0] x_q, y_q, ox, oy, ox_q, oy_q;
  logic [ProdW-1:0]          pxx_q, pyy_q, oxx_q, oyy_q;
  logic signed [ProdW-1:0]   pxy_q, oxy_q;
  logic [2*SampleW-1:0]      rdata;

  logic signed [WinW:0]     nsig;
  logic signed [MulOpW-1:0] op;
  logic signed [SumW-1:0]   s1, s2;
  logic signed [PnW-1:0]    pn_d, pn_q, diff;
  logic signed [PsW-1:0]    ps_d, ps_q;
  logic [VarW-1:0]          a_q, b_q;
  logic signed [CovW-1:0]   c_q;

  assign cfg_i.ready    = 1'b1;
  assign cfg_we         = cfg_i.valid;
  assign sample_i.ready = (state_q == F_IDLE);
  assign accept         = sample_i.valid && sample_i.ready;

  always_comb begin
    if (window_length_q < WinW'(WinMin)) begin
      n_eff = WinW'(WinMin);
    end else if (window_length_q > WinW'(WinMax)) begin
      n_eff = WinW'(WinMax);
    end else begin
      n_eff = window_length_q;
    end
  end

  assign widx_eff = sample_i.restart ? '0 : widx_q;
  assign fill_eff = sample_i.restart ? '0 : fill_q;
  assign drop_d   = (fill_eff >= n_eff);
  assign fill_new = drop_d ? fill_eff : fill_eff + 1'b1;
  assign raddr    = widx_eff - n_eff[AddrW-1:0];

  swc_ram #(
    .Width(2 * SampleW),
    .Depth(WinMax)
  ) u_hist (
    .clk_i  (clk_i),
    .we_i   (accept),
    .waddr_i(widx_eff),
    .wdata_i({sample_i.x_sample, sample_i.y_sample}),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  assign ox = drop_q ? signed'(rdata[2*SampleW-1:SampleW]) : '0;
  assign oy = drop_q ? signed'(rdata[SampleW-1:0]) : '0;

  assign nsig = signed'({1'b0, n_eff});

  always_comb begin
    case (k_q)
      2'd0: begin
        op = signed'({2'b00, sxx_q});
        s1 = sx_q;
        s2 = sx_q;
      end
      2'd1: begin
        op = signed'({2'b00, syy_q});
        s1 = sy_q;
        s2 = sy_q;
      end
      default: begin
        op = MulOpW'(sxy_q);
        s1 = sx_q;
        s2 = sy_q;
      end
    endcase
    pn_d = nsig * op;
    ps_d = s1 * s2;
    diff = pn_q - PnW'(ps_q);
  end

  always_comb begin
    state_d     = state_q;
    job_valid_o = 1'b0;
    case (state_q)
      F_IDLE: begin
        if (accept) begin
          state_d = F_LOAD;
        end
      end
      F_LOAD: state_d = F_SUM;
      F_SUM:  state_d = F_MUL;
      F_MUL: begin
        if (k_q == 2'd3) begin
          state_d = F_PUSH;
        end
      end
      F_PUSH: begin
        job_valid_o = 1'b1;
        if (job_ready_i) begin
          state_d = F_IDLE;
        end
      end
      default: state_d = F_IDLE;
    endcase
  end

  assign job_o.full = full_q;
  assign job_o.a    = a_q;
  assign job_o.b    = b_q;
  assign job_o.c    = c_q;
  assign job_o.n    = n_eff;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q         <= F_IDLE;
      window_length_q <= WinReset;
      fill_q          <= '0;
      widx_q          <= '0;
      k_q             <= '0;
      sx_q            <= '0;
      sy_q            <= '0;
      sxx_q           <= '0;
      syy_q           <= '0;
      sxy_q           <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_we) begin
        window_length_q <= cfg_i.window_length;
        fill_q          <= '0;
        widx_q          <= '0;
        sx_q            <= '0;
        sy_q            <= '0;
        sxx_q           <= '0;
        syy_q           <= '0;
        sxy_q           <= '0;
      end else begin
        if (accept) begin
          fill_q <= fill_new;
          widx_q <= widx_eff + 1'b1;
          if (sample_i.restart) begin
            sx_q  <= '0;
            sy_q  <= '0;
            sxx_q <= '0;
            syy_q <= '0;
            sxy_q <= '0;
          end
        end
        if (state_q == F_SUM) begin
          sx_q  <= sx_q + SumW'(x_q) - SumW'(ox_q);
          sy_q  <= sy_q + SumW'(y_q) - SumW'(oy_q);
          sxx_q <= sxx_q + SqW'(pxx_q) - SqW'(oxx_q);
          syy_q <= syy_q + SqW'(pyy_q) - SqW'(oyy_q);
          sxy_q <= sxy_q + XyW'(pxy_q) - XyW'(oxy_q);
        end
      end
      if (state_q == F_MUL) begin
        k_q <= k_q + 1'b1;
      end else begin
        k_q <= '0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      x_q    <= sample_i.x_sample;
      y_q    <= sample_i.y_sample;
      drop_q <= drop_d;
      full_q <= (fill_new >= n_eff);
    end
    if (state_q == F_LOAD) begin
      ox_q  <= ox;
      oy_q  <= oy;
      pxx_q <= ProdW'(x_q * x_q);
      pyy_q <= ProdW'(y_q * y_q);
      pxy_q <= ProdW'(x_q * y_q);
      oxx_q <= ProdW'(ox * ox);
      oyy_q <= ProdW'(oy * oy);
      oxy_q <= ProdW'(ox * oy);
    end
    if (state_q == F_MUL) begin
      pn_q <= pn_d;
      ps_q <= ps_d;
      case (k_q)
        2'd1:    a_q <= diff[VarW-1:0];
        2'd2:    b_q <= diff[VarW-1:0];
        2'd3:    c_q <= diff[CovW-1:0];
        default: ;
      endcase
    end
  end

endmodule

FILE: hw/rtl/swc_queue.sv
module swc_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_valid_i,
  output logic              push_ready_o,
  input  swc_pkg::swc_job_t push_data_i,
  output logic              pop_valid_o,
  input  logic              pop_ready_i,
  output swc_pkg::swc_job_t pop_data_o
);
  import swc_pkg::*;

  swc_job_t         entries_q [QDepth];
  logic [QPtrW-1:0] wptr_q, rptr_q;
  logic [QPtrW:0]   count_q;
  logic             push, pop;

  assign push_ready_o = (count_q != (QPtrW+1)'(QDepth));
  assign pop_valid_o  = (count_q != '0);
  assign pop_data_o   = entries_q[rptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      if (push) begin
        wptr_q <= wptr_q + 1'b1;
      end
      if (pop) begin
        rptr_q <= rptr_q + 1'b1;
      end
      if (push && !pop) begin
        count_q <= count_q + 1'b1;
      end else if (pop && !push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      entries_q[wptr_q] <= push_data_i;
    end
  end

endmodule

FILE: hw/rtl/swc_back.sv
module swc_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              job_valid_i,
  output logic              job_ready_o,
  input  swc_pkg::swc_job_t job_i,
  swc_out_if.source         result_o
);
  import swc_pkg::*;

  back_state_e state_q, state_d;

  logic [CntW-1:0] cnt_q, cov_cnt_q;
  logic            pop, load;
  logic            full_q, undef_q, cneg_q;
  logic [VarW-1:0] cmag, cmag_q, a_q, b_q;
  logic [DivW-1:0] d_q, crem_q;
  logic [DivW:0]   crem2;
  logic [VarW-1:0] cdiv_q, cq_q;

  logic [HalfW-1:0]   ma, mb;
  logic [RadW-1:0]    pp_ext, prod_q;

  logic [RootW+2:0] srem_q, sr2, trial;
  logic [RootW-1:0] root_q;

  logic [RootW+1:0] drem_q, dr2, dv;
  logic [FracW-1:0] dlow_q, dq_q;

  logic [CorrW-1:0]   qcap;
  logic [CovOutW-1:0] covm;

  logic                      out_valid_q, res_valid_q, undef_out_q;
  logic signed [CorrW-1:0]   corr_q;
  logic signed [CovOutW-1:0] cov_q;

  assign job_ready_o = (state_q == B_IDLE);
  assign pop         = job_valid_i && job_ready_o;
  assign cmag        = job_i.c[CovW-1] ? VarW'(-job_i.c) : job_i.c[VarW-1:0];
  assign load        = (state_q == B_OUT) && (cov_cnt_q == '0) &&
                       (!out_valid_q || result_o.ready);

  assign crem2 = {crem_q, cdiv_q[VarW-1]};

  always_comb begin
    case (cnt_q[1:0])
      2'd0: begin
        ma = a_q[HalfW-1:0];
        mb = b_q[HalfW-1:0];
        pp_ext = RadW'(ma * mb);
      end
      2'd1: begin
        ma = a_q[HalfW-1:0];
        mb = HalfW'(b_q[VarW-1:HalfW]);
        pp_ext = RadW'(ma * mb) << HalfW;
      end
      2'd2: begin
        ma = HalfW'(a_q[VarW-1:HalfW]);
        mb = b_q[HalfW-1:0];
        pp_ext = RadW'(ma * mb) << HalfW;
      end
      default: begin
        ma = HalfW'(a_q[VarW-1:HalfW]);
        mb = HalfW'(b_q[VarW-1:HalfW]);
        pp_ext = RadW'(ma * mb) << (2 * HalfW);
      end
    endcase
  end

  assign sr2   = {srem_q[RootW:0], prod_q[RadW-1:RadW-2]};
  assign trial = {1'b0, root_q, 2'b01};
  assign dr2   = {drem_q[RootW:0], dlow_q[FracW-1]};
  assign dv    = {1'b0, root_q, 1'b0};

  always_comb begin
    if (dq_q > FracW'(1 << (CorrW - 2))) begin
      qcap = CorrW'(1 << (CorrW - 2));
    end else begin
      qcap = CorrW'(dq_q);
    end
    if (cneg_q) begin
      if (cq_q > VarW'(64'h8000_0000)) begin
        covm = 32'h8000_0000;
      end else begin
        covm = cq_q[CovOutW-1:0];
      end
    end else begin
      if (cq_q > VarW'(64'h7FFF_FFFF)) begin
        covm = 32'h7FFF_FFFF;
      end else begin
        covm = cq_q[CovOutW-1:0];
      end
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      B_IDLE: begin
        if (pop) begin
          if (!job_i.full || job_i.a == '0 || job_i.b == '0) begin
            state_d = B_OUT;
          end else begin
            state_d = B_MUL;
          end
        end
      end
      B_MUL: begin
        if (cnt_q[1:0] == 2'd3) begin
          state_d = B_SQRT;
        end
      end
      B_SQRT: begin
        if (cnt_q == CntW'(RootW - 1)) begin
          state_d = B_DINIT;
        end
      end
      B_DINIT: state_d = B_DIV;
      B_DIV: begin
        if (cnt_q == CntW'(FracW - 1)) begin
          state_d = B_OUT;
        end
      end
      B_OUT: begin
        if (load) begin
          state_d = B_IDLE;
        end
      end
      default: state_d = B_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_IDLE;
      cnt_q       <= '0;
      cov_cnt_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_d != state_q) begin
        cnt_q <= '0;
      end else begin
        cnt_q <= cnt_q + 1'b1;
      end
      if (pop) begin
        cov_cnt_q <= job_i.full ? CntW'(VarW) : '0;
      end else if (cov_cnt_q != '0) begin
        cov_cnt_q <= cov_cnt_q - 1'b1;
      end
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (result_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      full_q  <= job_i.full;
      a_q     <= job_i.a;
      b_q     <= job_i.b;
      cneg_q  <= job_i.c[CovW-1];
      cmag_q  <= cmag;
      undef_q <= (job_i.a == '0) || (job_i.b == '0);
      d_q     <= DivW'(job_i.n * (job_i.n - 1'b1));
      cdiv_q  <= cmag;
      crem_q  <= '0;
      cq_q    <= '0;
      prod_q  <= '0;
    end else if (cov_cnt_q != '0) begin
      cdiv_q <= cdiv_q << 1;
      if (crem2 >= {1'b0, d_q}) begin
        crem_q <= DivW'(crem2 - {1'b0, d_q});
        cq_q   <= {cq_q[VarW-2:0], 1'b1};
      end else begin
        crem_q <= crem2[DivW-1:0];
        cq_q   <= {cq_q[VarW-2:0], 1'b0};
      end
    end
    case (state_q)
      B_MUL: begin
        prod_q <= prod_q + pp_ext;
        srem_q <= '0;
        root_q <= '0;
      end
      B_SQRT: begin
        prod_q <= prod_q << 2;
        if (sr2 >= trial) begin
          srem_q <= sr2 - trial;
          root_q <= {root_q[RootW-2:0], 1'b1};
        end else begin
          srem_q <= sr2;
          root_q <= {root_q[RootW-2:0], 1'b0};
        end
      end
      B_DINIT: begin
        drem_q <= (RootW+2)'(cmag_q) + (RootW+2)'(root_q >> FracW);
        dlow_q <= root_q[FracW-1:0];
        dq_q   <= '0;
      end
      B_DIV: begin
        dlow_q <= dlow_q << 1;
        if (dr2 >= dv) begin
          drem_q <= dr2 - dv;
          dq_q   <= {dq_q[FracW-2:0], 1'b1};
        end else begin
          drem_q <= dr2;
          dq_q   <= {dq_q[FracW-2:0], 1'b0};
        end
      end
      default: ;
    endcase
    if (load) begin
      res_valid_q <= full_q;
      undef_out_q <= full_q && undef_q;
      if (!full_q || undef_q) begin
        corr_q <= '0;
      end else begin
        corr_q <= cneg_q ? signed'(-qcap) : signed'(qcap);
      end
      if (!full_q) begin
        cov_q <= '0;
      end else begin
        cov_q <= cneg_q ? signed'(-covm) : signed'(covm);
      end
    end
  end

  assign result_o.valid                 = out_valid_q;
  assign result_o.result_valid          = res_valid_q;
  assign result_o.correlation           = corr_q;
  assign result_o.covariance            = cov_q;
  assign result_o.correlation_undefined = undef_out_q;

endmodule

FILE: hw/rtl/sliding_window_correlation_core.sv
// Channel    Dir  Payload
// sample_i   in   x_sample, y_sample, restart
// cfg_i      in   window_length
// result_o   out  result_valid, correlation, covariance, correlation_undefined
//
// Front end, per sample: history read, sum update, three products, then the job
// push; it takes no new sample until the job is queued. Back end: 4 partial
// products, 51-step square root, 17-step divide for a defined correlation; only
// the 51-step covariance divide when a variance is zero; neither while it fills.
// The back end's square root and divides set the sustained rate.
// A two-entry job queue decouples front and back; the result register frees
// the back end while a result waits. Reset needs no clearing pass.
module sliding_window_correlation_core (
  input  logic       clk_i,
  input  logic       rst_ni,
  swc_in_if.sink     sample_i,
  swc_cfg_if.sink    cfg_i,
  swc_out_if.source  result_o
);
  import swc_pkg::*;

  logic     fj_valid, fj_ready, bj_valid, bj_ready;
  swc_job_t fj_data, bj_data;

  swc_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .sample_i   (sample_i),
    .cfg_i      (cfg_i),
    .job_valid_o(fj_valid),
    .job_ready_i(fj_ready),
    .job_o      (fj_data)
  );

  swc_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_valid_i(fj_valid),
    .push_ready_o(fj_ready),
    .push_data_i (fj_data),
    .pop_valid_o (bj_valid),
    .pop_ready_i (bj_ready),
    .pop_data_o  (bj_data)
  );

  swc_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .job_valid_i(bj_valid),
    .job_ready_o(bj_ready),
    .job_i      (bj_data),
    .result_o   (result_o)
  );

endmodule
